@@ design/dram_bank_request_scheduler_macros.svh @@
// Assertion macros shared by the scheduler checker.
`ifndef DRAM_BANK_REQUEST_SCHEDULER_MACROS_SVH
`define DRAM_BANK_REQUEST_SCHEDULER_MACROS_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define DBRS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dbrs check failed");
// Assert that an antecedent implies a consequent in the next cycle.
`define DBRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dbrs check failed");
`endif

@@ design/dbrs_pkg.sv @@
// Package: sizes, register indexes and record types of the bank scheduler.
`default_nettype none
package dbrs_pkg;
  localparam int QueueDepth = 16;
  localparam int BankCount  = 8;
  localparam int RowBits    = 16;
  localparam int QIdxW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);
  localparam int BankW      = 3;
  localparam int CfgW       = 8;
  localparam int CfgIdxW    = 3;

  localparam logic [CfgIdxW-1:0] RegPolicy  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHitLat  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMissLat = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBanks   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegQLimit  = 3'd4;

  typedef struct packed {
    logic [15:0]        serial;
    logic [3:0]         thread;
    logic [BankW-1:0]   bank;
    logic [RowBits-1:0] row;
  } entry_t;

  // Search request from sequencer to the queue unit, and its answer.
  typedef struct packed {
    logic               fcfs;
    logic [BankW-1:0]   bank;
    logic               row_open;
    logic [RowBits-1:0] row;
  } search_req_t;

  typedef struct packed {
    logic             found;
    logic [QIdxW-1:0] slot;
    entry_t           entry;
  } search_rsp_t;
endpackage
`default_nettype wire

@@ design/dbrs_if.sv @@
// Valid/ready channel interface carrying one payload word.
`default_nettype none
interface dbrs_if #(parameter type T = logic) (input wire logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/dbrs_queue.sv @@
// Request queue: taken marks, compaction, oldest-match search and append.
`default_nettype none
module dbrs_queue import dbrs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              compact,
  input  wire search_req_t       sreq,
  output search_rsp_t            srsp,
  input  wire logic              take,
  input  wire logic [QIdxW-1:0]  take_slot,
  input  wire logic              push,
  input  wire entry_t            push_entry,
  output logic [QCntW-1:0]       count
);
  entry_t               mem [QueueDepth];
  logic [QueueDepth-1:0] taken;
  logic [QueueDepth-1:0] match_any;
  logic [QueueDepth-1:0] match_hit;
  logic [QueueDepth-1:0] live;
  logic [QIdxW-1:0]      pos [QueueDepth];
  logic [QCntW-1:0]      kept;

  // Mark live slots and matches in parallel.
  always_comb begin
    for (int i = 0; i < QueueDepth; i++) begin
      live[i]      = (QCntW'(i) < count) && !taken[i];
      match_any[i] = live[i] && (mem[i].bank == sreq.bank);
      match_hit[i] = match_any[i] && sreq.row_open && (mem[i].row == sreq.row);
    end
  end

  // Pick the oldest row hit (FR-FCFS only), else the oldest match.
  always_comb begin
    srsp.found = 1'b0;
    srsp.slot  = '0;
    for (int i = QueueDepth - 1; i >= 0; i--) begin
      if (match_any[i]) begin
        srsp.found = 1'b1;
        srsp.slot  = QIdxW'(i);
      end
    end
    if (!sreq.fcfs && (match_hit != '0)) begin
      for (int i = QueueDepth - 1; i >= 0; i--) begin
        if (match_hit[i]) srsp.slot = QIdxW'(i);
      end
    end
    srsp.entry = mem[srsp.slot];
  end

  // Destination of each kept entry on compaction.
  always_comb begin
    kept = '0;
    for (int i = 0; i < QueueDepth; i++) begin
      pos[i] = kept[QIdxW-1:0];
      if (live[i]) kept = kept + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (compact) begin
      for (int i = 0; i < QueueDepth; i++) begin
        if (live[i]) mem[pos[i]] <= mem[i];
      end
    end else if (push) begin
      mem[count[QIdxW-1:0]] <= push_entry;
    end
  end

  // Marks are cleared on compaction, so an appended slot is already unmarked.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      taken <= '0;
    end else if (compact) begin
      count <= kept;
      taken <= '0;
    end else begin
      if (take) taken[take_slot] <= 1'b1;
      if (push) count <= count + 1'b1;
    end
  end
endmodule
`default_nettype wire

@@ design/dram_bank_request_scheduler.sv @@
// Top level: tick sequencer, bank state and result channel.
// Usage: each input word on req is one clock tick of the memory model, with
// req_valid_in telling whether it offers a new request. For every tick the
// block returns one result word per bank in use (banks_in_use, capped at 8)
// on res, in ascending bank order, last_bank marking the final one; 0 banks
// give none. Steps of a tick: the queue is compacted, then each bank in use
// is served in turn, each using the single shared search over the 16 queue
// slots (oldest row hit first under FR-FCFS, else oldest match); then the
// result words go out while res takes them. req is ready only in the idle
// state. A stall on res holds the current word and the sequencer.
// Reset (rst, synchronous) empties the queue, idles all banks, closes all
// rows and loads the register defaults: FR-FCFS, hit 2, miss 6, 8 banks,
// queue limit 16. Registers are written over cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle, which the block
// itself does not enforce.
`default_nettype none
module dram_bank_request_scheduler import dbrs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [CfgW-1:0]    cfg_data,
  input  wire logic               req_valid_in,
  dbrs_if.sink                    req,
  dbrs_if.source                  res
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_COMPACT = 4'b0010, S_BANK = 4'b0100, S_OUT = 4'b1000
  } state_t;

  state_t state;
  logic       policy_mode;
  logic [7:0] hit_latency, miss_latency;
  logic [3:0] banks_in_use;
  logic [4:0] queue_limit;

  entry_t           in_entry;
  logic             in_valid;
  logic [BankW:0]   bank_cnt;
  logic [BankW:0]   nb;
  logic [QCntW-1:0] limit;
  logic             acc;

  logic [7:0]           busy [BankCount];
  entry_t               cur  [BankCount];
  logic [BankCount-1:0] row_open, hit_flag, issued;

  search_req_t sreq;
  search_rsp_t srsp;
  logic [QCntW-1:0] qcount;
  logic take, push, compact;
  logic [BankW-1:0] cb;
  logic [7:0] busy_dec;
  logic hit;
  logic done;
  logic bank_en;

  assign nb    = (banks_in_use > 4'(BankCount)) ? (BankW+1)'(BankCount)
                                                : banks_in_use;
  assign limit = (queue_limit > 5'(QueueDepth)) ? QCntW'(QueueDepth) : queue_limit;
  assign cb    = bank_cnt[BankW-1:0];
  assign bank_en = (bank_cnt < nb);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode <= 1'b1; hit_latency <= 8'd2; miss_latency <= 8'd6;
      banks_in_use <= 4'd8; queue_limit <= 5'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegPolicy:  policy_mode  <= cfg_data[0];
        RegHitLat:  hit_latency  <= cfg_data;
        RegMissLat: miss_latency <= cfg_data;
        RegBanks:   banks_in_use <= cfg_data[3:0];
        RegQLimit:  queue_limit  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Shared search for the bank under service.
  assign busy_dec      = (busy[cb] != 8'd0) ? busy[cb] - 8'd1 : 8'd0;
  assign sreq.fcfs     = !policy_mode;
  assign sreq.bank     = cb;
  assign sreq.row_open = row_open[cb];
  assign sreq.row      = cur[cb].row;
  assign hit  = row_open[cb] && (srsp.entry.row == cur[cb].row);
  assign take = (state == S_BANK) && bank_en && (busy_dec == 8'd0) && srsp.found;
  assign compact = (state == S_COMPACT);
  assign push = (state == S_BANK) && (bank_cnt + 1'b1 >= nb) && in_valid
                && (qcount < limit);
  assign req.ready = (state == S_IDLE);

  dbrs_queue u_queue (
    .clk, .rst, .compact, .sreq, .srsp, .take,
    .take_slot(srsp.slot), .push, .push_entry(in_entry), .count(qcount)
  );

  always_comb begin
    done = (qcount == '0);
    for (int b = 0; b < BankCount; b++) begin
      if ((BankW+1)'(b) < nb && busy[b] != 8'd0) done = 1'b0;
    end
  end

  // Tick sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bank_cnt <= '0;
      acc <= 1'b0;
      in_valid <= 1'b0;
      row_open <= '0;
      hit_flag <= '0;
      issued <= '0;
      for (int b = 0; b < BankCount; b++) busy[b] <= 8'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            in_entry <= req.data;
            in_valid <= req_valid_in;
            state    <= S_COMPACT;
          end
        end
        S_COMPACT: begin
          bank_cnt <= '0;
          acc      <= 1'b0;
          issued   <= '0;
          state    <= S_BANK;
        end
        S_BANK: begin
          // Start a new request on an idle bank, else count down.
          if (take) begin
            busy[cb]     <= hit ? hit_latency : miss_latency;
            hit_flag[cb] <= hit;
            cur[cb]      <= srsp.entry;
            row_open[cb] <= 1'b1;
            issued[cb]   <= 1'b1;
          end else if (bank_en) begin
            busy[cb] <= busy_dec;
          end
          if (push) acc <= 1'b1;
          if (bank_cnt + 1'b1 >= nb) begin
            bank_cnt <= '0;
            state    <= (nb == '0) ? S_IDLE : S_OUT;
          end else begin
            bank_cnt <= bank_cnt + 1'b1;
          end
        end
        S_OUT: begin
          if (res.ready) begin
            if (bank_cnt + 1'b1 >= nb) begin
              bank_cnt <= '0;
              state    <= S_IDLE;
            end else begin
              bank_cnt <= bank_cnt + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result word for the bank under report.
  assign res.valid = (state == S_OUT);
  always_comb begin
    res.data.bank_index = cb;
    res.data.issued     = issued[cb];
    res.data.out_serial = row_open[cb] ? cur[cb].serial : 16'd0;
    res.data.out_thread = row_open[cb] ? cur[cb].thread : 4'd0;
    res.data.out_row    = row_open[cb] ? cur[cb].row : 16'd0;
    res.data.was_hit    = row_open[cb] && hit_flag[cb];
    res.data.busy_left  = busy[cb];
    res.data.accepted   = acc;
    res.data.all_done   = done;
    res.data.last_bank  = (bank_cnt + 1'b1 == nb);
  end
endmodule
`default_nettype wire

@@ design/dbrs_checker.sv @@
// Port-level checker for the bank scheduler, bound to the top level.
`default_nettype none
`include "dram_bank_request_scheduler_macros.svh"
module dbrs_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic res_valid,
  input wire logic res_ready,
  input wire logic res_last,
  input wire logic [2:0] res_bank
);
  `DBRS_ASSERT_IMPL(a_no_overlap, clk, rst, res_valid, !req_ready)
  `DBRS_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && req_ready, !req_ready)
  `DBRS_ASSERT_NEXT(a_bank_step, clk, rst, res_valid && res_ready && !res_last,
                    res_valid && res_bank == $past(res_bank) + 3'd1)
  `DBRS_ASSERT_NEXT(a_hold, clk, rst, res_valid && !res_ready,
                    res_valid && $stable(res_bank))
endmodule
bind dram_bank_request_scheduler dbrs_checker u_dbrs_checker (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .res_valid(res.valid), .res_ready(res.ready),
  .res_last(res.data.last_bank), .res_bank(res.data.bank_index)
);
`default_nettype wire
